[hdl/eqr_pkg.sv]
// Package for the Euler-angle to quaternion rotation unit.
// Holds fixed-point constants, the CORDIC arctangent table and shared helpers.
// Depends on nothing.
package eqr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FULL_TURN_Q16 = 23592960;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] HALF_TURN_PHASE = 34'sd1073741824;

    // Arctangents of 2^-k in units of 2^-32 of a turn.
    function automatic logic signed [33:0] atan_turns(input logic [4:0] k);
        logic signed [33:0] r;
        begin
            case (k)
                5'd0: r = 34'sd536870912;
                5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;
                5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;
                5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10679838;
                5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;
                5'd9: r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                5'd24: r = 34'sd41;
                5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;
                5'd27: r = 34'sd5;
                5'd28: r = 34'sd3;
                5'd29: r = 34'sd1;
                5'd30: r = 34'sd1;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    // Q2.30 product with round half up: floor((a*b + 2^29) / 2^30).
    function automatic logic signed [35:0] mul30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b + 68'sd536870912;
            return p[65:30];
        end
    endfunction

endpackage

[hdl/euler_to_quaternion_rotate_vector_unit.sv]
// Top level of the Euler-angle to quaternion rotation unit.
// Depends on eqr_pkg and eqr_sincos.
//
//  channel | handshake            | fields
//  in      | in_valid / in_stall  | angle_x_deg angle_y_deg angle_z_deg vec_x vec_y vec_z
//  out     | out_valid / out_stall| quat_w quat_x quat_y quat_z rot_x rot_y rot_z
//
// One word enters per cycle while in_stall is low.
// The pipeline holds the three angle-reduction stages, the CORDIC rotation
// stages, the sign-flip stage and the multiplier stages.
// Reset clears only the valid bits of the pipeline.
// A stall at the output freezes the whole pipeline; in_stall follows out_stall
// when the output stage holds a word.
module euler_to_quaternion_rotate_vector_unit #(
    parameter int CORDIC_STEPS = eqr_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle_x_deg,
    input  logic signed [31:0] angle_y_deg,
    input  logic signed [31:0] angle_z_deg,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] quat_w,
    output logic signed [17:0] quat_x,
    output logic signed [17:0] quat_y,
    output logic signed [17:0] quat_z,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z
);
    localparam int SC_LAT = CORDIC_STEPS + 4;
    localparam int LAT = SC_LAT + 6;

    logic en;
    logic [LAT-1:0] vld_reg;

    assign en = !(out_stall && vld_reg[LAT-1]);
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    logic signed [33:0] cp, sp, cr, sr, cy, sy;
    eqr_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
        .clk(clk), .en(en), .angle(angle_x_deg), .cs(cp), .sn(sp));
    eqr_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
        .clk(clk), .en(en), .angle(angle_y_deg), .cs(cr), .sn(sr));
    eqr_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
        .clk(clk), .en(en), .angle(angle_z_deg), .cs(cy), .sn(sy));

    // The vector rides a delay line alongside the angle pipeline.
    logic signed [31:0] vx_reg [0:LAT-3];
    logic signed [31:0] vy_reg [0:LAT-3];
    logic signed [31:0] vz_reg [0:LAT-3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= vec_x;
            vy_reg[0] <= vec_y;
            vz_reg[0] <= vec_z;
            for (int i = 1; i < LAT - 2; i++)
            begin
                vx_reg[i] <= vx_reg[i-1];
                vy_reg[i] <= vy_reg[i-1];
                vz_reg[i] <= vz_reg[i-1];
            end
        end
    end

    // Stage A: pair products.
    logic signed [35:0] crcp_reg, srsp_reg, crsp_reg, srcp_reg;
    logic signed [33:0] cy_a_reg, sy_a_reg;
    // Stage B: quaternion in Q2.30.
    logic signed [33:0] qw_reg, qx_reg, qy_reg, qz_reg;
    // Stage C: quadratic terms.
    logic signed [35:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [35:0] wx_reg, wy_reg, wz_reg;
    logic signed [33:0] qw_c_reg, qx_c_reg, qy_c_reg, qz_c_reg;
    // Stage D: matrix.
    logic signed [39:0] m_reg [0:8];
    logic signed [33:0] qw_d_reg, qx_d_reg, qy_d_reg, qz_d_reg;
    // Stage E: matrix-by-component terms.
    logic signed [39:0] t_reg [0:8];
    logic signed [33:0] qw_e_reg, qx_e_reg, qy_e_reg, qz_e_reg;

    function automatic logic signed [39:0] mul_mv(input logic signed [39:0] m,
                                                 input logic signed [31:0] v);
        logic signed [71:0] p;
        begin
            p = m * v + 72'sd536870912;
            return p[69:30];
        end
    endfunction

    function automatic logic signed [17:0] qout(input logic signed [33:0] q);
        logic signed [33:0] r;
        begin
            r = (q + 34'sd8192) >>> 14;
            if (r > 34'sd65536)
            begin
                r = 34'sd65536;
            end
            if (r < -34'sd65536)
            begin
                r = -34'sd65536;
            end
            return r[17:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] s);
        logic signed [31:0] r;
        begin
            if (s > 42'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (s < -42'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = s[31:0];
            end
            return r;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= eqr_pkg::mul30(cr, cp);
            srsp_reg <= eqr_pkg::mul30(sr, sp);
            crsp_reg <= eqr_pkg::mul30(cr, sp);
            srcp_reg <= eqr_pkg::mul30(sr, cp);
            cy_a_reg <= cy;
            sy_a_reg <= sy;

            qw_reg <= 34'(eqr_pkg::mul30(34'(crcp_reg), cy_a_reg)
                    + eqr_pkg::mul30(34'(srsp_reg), sy_a_reg));
            qx_reg <= 34'(eqr_pkg::mul30(34'(crsp_reg), cy_a_reg)
                    + eqr_pkg::mul30(34'(srcp_reg), sy_a_reg));
            qy_reg <= 34'(eqr_pkg::mul30(34'(srcp_reg), cy_a_reg)
                    - eqr_pkg::mul30(34'(crsp_reg), sy_a_reg));
            qz_reg <= 34'(eqr_pkg::mul30(34'(crcp_reg), sy_a_reg)
                    - eqr_pkg::mul30(34'(srsp_reg), cy_a_reg));

            xx_reg <= eqr_pkg::mul30(qx_reg, qx_reg);
            yy_reg <= eqr_pkg::mul30(qy_reg, qy_reg);
            zz_reg <= eqr_pkg::mul30(qz_reg, qz_reg);
            xy_reg <= eqr_pkg::mul30(qx_reg, qy_reg);
            xz_reg <= eqr_pkg::mul30(qx_reg, qz_reg);
            yz_reg <= eqr_pkg::mul30(qy_reg, qz_reg);
            wx_reg <= eqr_pkg::mul30(qw_reg, qx_reg);
            wy_reg <= eqr_pkg::mul30(qw_reg, qy_reg);
            wz_reg <= eqr_pkg::mul30(qw_reg, qz_reg);
            qw_c_reg <= qw_reg;
            qx_c_reg <= qx_reg;
            qy_c_reg <= qy_reg;
            qz_c_reg <= qz_reg;

            m_reg[0] <= 40'sd1073741824 - 40'(yy_reg + zz_reg) * 2;
            m_reg[1] <= 40'(xy_reg - wz_reg) * 2;
            m_reg[2] <= 40'(xz_reg + wy_reg) * 2;
            m_reg[3] <= 40'(xy_reg + wz_reg) * 2;
            m_reg[4] <= 40'sd1073741824 - 40'(xx_reg + zz_reg) * 2;
            m_reg[5] <= 40'(yz_reg - wx_reg) * 2;
            m_reg[6] <= 40'(xz_reg - wy_reg) * 2;
            m_reg[7] <= 40'(yz_reg + wx_reg) * 2;
            m_reg[8] <= 40'sd1073741824 - 40'(xx_reg + yy_reg) * 2;
            qw_d_reg <= qw_c_reg;
            qx_d_reg <= qx_c_reg;
            qy_d_reg <= qy_c_reg;
            qz_d_reg <= qz_c_reg;

            for (int r = 0; r < 3; r++)
            begin
                t_reg[3*r]   <= mul_mv(m_reg[3*r],   vx_reg[LAT-3]);
                t_reg[3*r+1] <= mul_mv(m_reg[3*r+1], vy_reg[LAT-3]);
                t_reg[3*r+2] <= mul_mv(m_reg[3*r+2], vz_reg[LAT-3]);
            end
            qw_e_reg <= qw_d_reg;
            qx_e_reg <= qx_d_reg;
            qy_e_reg <= qy_d_reg;
            qz_e_reg <= qz_d_reg;

            quat_w <= qout(qw_e_reg);
            quat_x <= qout(qx_e_reg);
            quat_y <= qout(qy_e_reg);
            quat_z <= qout(qz_e_reg);
            rot_x <= sat32(42'(t_reg[0]) + 42'(t_reg[1]) + 42'(t_reg[2]));
            rot_y <= sat32(42'(t_reg[3]) + 42'(t_reg[4]) + 42'(t_reg[5]));
            rot_z <= sat32(42'(t_reg[6]) + 42'(t_reg[7]) + 42'(t_reg[8]));
        end
    end
endmodule

[hdl/eqr_sincos.sv]
// Pipelined half-angle sine and cosine: modulo-360 reduction then CORDIC.
// Depends on eqr_pkg.
module eqr_sincos #(
    parameter int CORDIC_STEPS = eqr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  angle,
    output logic signed [33:0]  cs,
    output logic signed [33:0]  sn
);
    // Stage 0 reduces the angle modulo a full turn. Stages 1 and 2 turn the
    // remainder into the half-angle phase. Then there is one stage per rotation,
    // and a last stage applies the sign flip.
    localparam logic [13:0] RECIP45_HI = 14'd11651;
    localparam logic [25:0] RECIP45    = 26'd47721859;

    logic [24:0]        rem_reg;
    logic [18:0]        qa_reg;
    logic [5:0]         ra_reg;
    logic signed [33:0] z_reg [0:CORDIC_STEPS];
    logic signed [33:0] x_reg [0:CORDIC_STEPS];
    logic signed [33:0] y_reg [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];

    logic [12:0]        hi_biased;
    logic [26:0]        hi_prod;
    logic [12:0]        hi_sub;
    logic [5:0]         hi_rem;
    logic [5:0]         hi_mod;
    logic [24:0]        rem_next;
    logic [49:0]        rem_prod;
    logic [18:0]        qa_next;
    logic [5:0]         ra_next;
    logic [31:0]        frac_prod;
    logic signed [33:0] phase;

    // A full turn is 45 * 2^19, so only the bits above bit 18 need a modulo-45
    // reduction. Adding 4096, which is 1 modulo 45, makes that part unsigned.
    // The divisions by 45 use reciprocal multiplies that are exact over the
    // ranges involved.
    always_comb
    begin
        hi_biased = {~angle[31], angle[30:19]};
        hi_prod = 27'(hi_biased) * 27'(RECIP45_HI);
        hi_sub = 13'(hi_prod[26:19]) * 13'd45;
        hi_rem = 6'(hi_biased - hi_sub);
        if (hi_rem == 6'd0)
        begin
            hi_mod = 6'd44;
        end
        else
        begin
            hi_mod = hi_rem - 6'd1;
        end
        rem_next = {hi_mod, angle[18:0]};

        // The phase is floor(rem * 4096 / 45), split as rem = 45 * qa + ra.
        rem_prod = 50'(rem_reg) * 50'(RECIP45);
        qa_next = rem_prod[49:31];
        ra_next = 6'(rem_reg - 25'(qa_next) * 25'd45);

        frac_prod = 32'(ra_reg) * 32'(RECIP45);
        phase = 34'({qa_reg, 12'd0}) + 34'(frac_prod[31:19]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            qa_reg <= qa_next;
            ra_reg <= ra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (phase >= eqr_pkg::HALF_TURN_PHASE)
            begin
                z_reg[0] <= phase - (eqr_pkg::HALF_TURN_PHASE <<< 1);
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= phase;
                flip_reg[0] <= 1'b0;
            end
            x_reg[0] <= eqr_pkg::CORDIC_GAIN_Q30;
            y_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        localparam logic [4:0] K = 5'(i % 32);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> K);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> K);
                    z_reg[i+1] <= z_reg[i] - eqr_pkg::atan_turns(K);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> K);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> K);
                    z_reg[i+1] <= z_reg[i] + eqr_pkg::atan_turns(K);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sn <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end
endmodule

[verif/euler_to_quaternion_rotate_vector_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for the Euler-angle to quaternion rotation unit.
// Depends on eqr_pkg and euler_to_quaternion_rotate_vector_unit; checks every word
// against a fixed-point predictor held in a small scoreboard class.
module euler_to_quaternion_rotate_vector_unit_tb;

    localparam int  STEPS       = eqr_pkg::CORDIC_STEPS_DEF;
    localparam int  NUM_RANDOM  = 600;
    localparam int  STALL_LIMIT = 5000;
    localparam int  DRAIN_WAIT  = STEPS + 30;
    localparam int  DEG         = 65536;

    typedef struct {
        logic signed [31:0] ax, ay, az, vx, vy, vz;
    } orient_word_t;

    typedef struct {
        logic signed [17:0] qw, qx, qy, qz;
        logic signed [31:0] rx, ry, rz;
    } rot_result_t;

    class RotationScoreboard;
        rot_result_t pending[$];
        int          errors;
        longint      atan_tab[32];

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                         81, 41, 20, 10, 5, 3, 1, 1, 0};
            errors = 0;
        endfunction

        function longint rmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        // Half-angle cosine and sine in Q2.30, folded into the CORDIC range.
        function void half_angle(input logic signed [31:0] ang, output longint c,
                                 output longint s);
            longint a, z, x, y, nx;
            bit     flip;
            int     k;
            a = longint'(ang) % longint'(eqr_pkg::FULL_TURN_Q16);
            if (a < 0)
                a += eqr_pkg::FULL_TURN_Q16;
            z = (a <<< 15) / 360;
            flip = 0;
            if (z >= (64'sd1 <<< 30))
            begin
                z -= (64'sd1 <<< 31);
                flip = 1;
            end
            x = 652032874;
            y = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                k = i & 31;
                if (z >= 0)
                begin
                    nx = x - (y >>> k);
                    y  = y + (x >>> k);
                    z -= atan_tab[k];
                end
                else
                begin
                    nx = x + (y >>> k);
                    y  = y - (x >>> k);
                    z += atan_tab[k];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic signed [17:0] quat_clamp(longint q);
            longint r;
            r = (q + 8192) >>> 14;
            if (r > 65536)
                r = 65536;
            if (r < -65536)
                r = -65536;
            return r[17:0];
        endfunction

        function logic signed [31:0] row_dot(longint m0, longint m1, longint m2,
                                             longint v0, longint v1, longint v2);
            longint acc;
            acc = rmul(m0, v0) + rmul(m1, v1) + rmul(m2, v2);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            return acc[31:0];
        endfunction

        function void note_input(orient_word_t w);
            longint cp, sp, cr, sr, cy, sy, qw, qx, qy, qz;
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
            rot_result_t r;
            half_angle(w.ax, cp, sp);
            half_angle(w.ay, cr, sr);
            half_angle(w.az, cy, sy);
            one = 64'sd1 <<< 30;
            qw = rmul(rmul(cr, cp), cy) + rmul(rmul(sr, sp), sy);
            qx = rmul(rmul(cr, sp), cy) + rmul(rmul(sr, cp), sy);
            qy = rmul(rmul(sr, cp), cy) - rmul(rmul(cr, sp), sy);
            qz = rmul(rmul(cr, cp), sy) - rmul(rmul(sr, sp), cy);
            xx = rmul(qx, qx); yy = rmul(qy, qy); zz = rmul(qz, qz);
            xy = rmul(qx, qy); xz = rmul(qx, qz); yz = rmul(qy, qz);
            wx = rmul(qw, qx); wy = rmul(qw, qy); wz = rmul(qw, qz);
            r.qw = quat_clamp(qw);
            r.qx = quat_clamp(qx);
            r.qy = quat_clamp(qy);
            r.qz = quat_clamp(qz);
            r.rx = row_dot(one - 2 * (yy + zz), 2 * (xy - wz), 2 * (xz + wy),
                           w.vx, w.vy, w.vz);
            r.ry = row_dot(2 * (xy + wz), one - 2 * (xx + zz), 2 * (yz - wx),
                           w.vx, w.vy, w.vz);
            r.rz = row_dot(2 * (xz - wy), 2 * (yz + wx), one - 2 * (xx + yy),
                           w.vx, w.vy, w.vz);
            pending.push_back(r);
        endfunction

        function void check(rot_result_t got);
            rot_result_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.qw !== e.qw) begin $error("quat_w exp %0d got %0d", e.qw, got.qw); errors++; end
            if (got.qx !== e.qx) begin $error("quat_x exp %0d got %0d", e.qx, got.qx); errors++; end
            if (got.qy !== e.qy) begin $error("quat_y exp %0d got %0d", e.qy, got.qy); errors++; end
            if (got.qz !== e.qz) begin $error("quat_z exp %0d got %0d", e.qz, got.qz); errors++; end
            if (got.rx !== e.rx) begin $error("rot_x exp %0d got %0d", e.rx, got.rx); errors++; end
            if (got.ry !== e.ry) begin $error("rot_y exp %0d got %0d", e.ry, got.ry); errors++; end
            if (got.rz !== e.rz) begin $error("rot_z exp %0d got %0d", e.rz, got.rz); errors++; end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] angle_x_deg = '0, angle_y_deg = '0, angle_z_deg = '0;
    logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [17:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] rot_x, rot_y, rot_z;

    RotationScoreboard rot_board = new();
    int  words_in = 0;
    int  idle_cycles = 0;
    bit  busy_phase = 0;

    euler_to_quaternion_rotate_vector_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .angle_x_deg(angle_x_deg), .angle_y_deg(angle_y_deg), .angle_z_deg(angle_z_deg),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= (!busy_phase && $urandom_range(99) < 32);

    // Sample both channels at the rising edge, and watch for a hung pipeline.
    always @(posedge clk)
    begin
        orient_word_t w;
        rot_result_t  r;
        bit moved;
        moved = 0;
        if (rst_n && in_valid && !in_stall)
        begin
            w = '{angle_x_deg, angle_y_deg, angle_z_deg, vec_x, vec_y, vec_z};
            rot_board.note_input(w);
            words_in++;
            moved = 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r = '{quat_w, quat_x, quat_y, quat_z, rot_x, rot_y, rot_z};
            rot_board.check(r);
            moved = 1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (rst_n && idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(orient_word_t w);
        int seen;
        while (!busy_phase && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        angle_x_deg <= w.ax; angle_y_deg <= w.ay; angle_z_deg <= w.az;
        vec_x       <= w.vx; vec_y       <= w.vy; vec_z       <= w.vz;
        seen = words_in;
        do @(negedge clk); while (words_in == seen);
    endtask

    function automatic logic signed [31:0] pick_angle();
        if ($urandom_range(2) == 0)
            return $urandom;
        return $signed($urandom_range(1440)) * DEG - 720 * DEG
               + $signed($urandom_range(65535));
    endfunction

    function automatic logic signed [31:0] pick_coord();
        if ($urandom_range(1) == 0)
            return $urandom;
        return $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
    endfunction

    initial
    begin
        orient_word_t dir[$];
        orient_word_t w;
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // Forward vector, quadrant boundaries, full turns and field extremes.
        dir.push_back('{0, 0, 0, 0, 0, 65536});
        dir.push_back('{90 * DEG, 0, 0, 0, 0, 65536});
        dir.push_back('{0, 90 * DEG, 0, 0, 0, 65536});
        dir.push_back('{0, 0, 90 * DEG, 65536, 0, 0});
        dir.push_back('{180 * DEG, 180 * DEG, 180 * DEG, 65536, 65536, 65536});
        dir.push_back('{270 * DEG, -90 * DEG, 360 * DEG, 0, 65536, 0});
        dir.push_back('{-360 * DEG, 359 * DEG, -180 * DEG, 100, -100, 7});
        dir.push_back('{179 * DEG + 65535, 180 * DEG - 1, 180 * DEG + 1, 3, 4, 5});
        dir.push_back('{mx, mx, mx, mx, mx, mx});
        dir.push_back('{mn, mn, mn, mn, mn, mn});
        dir.push_back('{mx, mn, 0, mx, mn, mx});
        dir.push_back('{0, 0, 0, mx, mx, mx});
        dir.push_back('{0, 0, 0, mn, mn, mn});
        dir.push_back('{45 * DEG, 45 * DEG, 45 * DEG, mx, mx, mx});
        dir.push_back('{45 * DEG, 45 * DEG, 45 * DEG, mn, mn, mn});
        dir.push_back('{30 * DEG, 60 * DEG, 120 * DEG, mx, mn, mx});
        dir.push_back('{-1, -1, -1, -1, -1, -1});
        dir.push_back('{1, 1, 1, 1, 1, 1});
        dir.push_back('{720 * DEG, -720 * DEG, 540 * DEG, 0, 0, 65536});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir[i])
            send_word(dir[i]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            busy_phase = (n >= 150 && n < 260);
            if (n == 350)
            begin
                // Let the pipeline drain completely before going on.
                in_valid <= 1'b0;
                while (rot_board.pending.size() != 0)
                    @(negedge clk);
            end
            w = '{pick_angle(), pick_angle(), pick_angle(),
                  pick_coord(), pick_coord(), pick_coord()};
            send_word(w);
        end
        busy_phase = 0;
        in_valid <= 1'b0;

        while (rot_board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (rot_board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
